// ===== hdl/tbu_pkg.sv =====
// Shared types and fixed constants of the triangle tangent/bitangent unit.
package tbu_pkg;

   // Fraction bits gained by the quotient: Q.24 over Q.24 gives Q16.16.
   localparam int FRAC_SHIFT = 16;

   // Command to the shared multiply-accumulate unit.
   typedef struct packed {
      logic valid;  // a product is issued this cycle
      logic sub;    // 1: subtract the product from the sum, 0: load it
   } mul_cmd_type;

endpackage

// ===== hdl/triangle_tangent_bitangent_unit.sv =====
// Top level of the triangle tangent/bitangent unit: vertex store, sequencer and result port.
//
//   channel | direction | tdata fields (low bit up)                      | tuser
//   --------+-----------+------------------------------------------------+-----------
//   req     | in        | pos_x, pos_y, pos_z, tex_u, tex_v (COORD_BITS) | none
//   rsp     | out       | tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z | degenerate
//
// The first and second corner of a triangle are each taken and stored.
// The third corner starts a sequence on one shared multiplier and one serial divider:
// two products for the determinant, then per component two products that feed the
// divider, six components in all; a zero determinant ends the sequence at its check.
// Reset is synchronous and leaves the unit waiting for a first corner with no result held.
// A result waits in its register until taken; first and second corners are still accepted
// meanwhile, but a third corner waits until the previous result has been taken.
module triangle_tangent_bitangent_unit #(
   parameter int COORD_BITS = 16,
   parameter int OUT_BITS   = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // pos_x, pos_y, pos_z, tex_u, tex_v, each COORD_BITS wide, zero padded to bytes
   input  logic [((5*COORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z, each OUT_BITS wide, zero padded
   output logic [((6*OUT_BITS+7)/8)*8-1:0]   rsp_tdata,
   // degenerate
   output logic [0:0]           rsp_tuser
);

   localparam int OPW   = COORD_BITS + 1;      // edge and delta width
   localparam int ACCW  = 2 * OPW + 1;         // cross product width
   localparam int RSP_W = ((6 * OUT_BITS + 7) / 8) * 8;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DET_MUL0,
      S_DET_MUL1,
      S_DET_FILL,
      S_DET_CHK,
      S_CMP_MUL0,
      S_CMP_MUL1,
      S_CMP_FILL,
      S_DIV_GO,
      S_DIV_WAIT
   } state_type;

   state_type                     state_ff;
   logic [1:0]                    corner_ff;
   logic signed [COORD_BITS-1:0]  held_pos_ff [2][3];
   logic signed [COORD_BITS-1:0]  held_tex_ff [2][2];
   logic signed [OPW-1:0]         e1_ff [3];
   logic signed [OPW-1:0]         e2_ff [3];
   logic signed [OPW-1:0]         du1_ff;
   logic signed [OPW-1:0]         dv1_ff;
   logic signed [OPW-1:0]         du2_ff;
   logic signed [OPW-1:0]         dv2_ff;
   logic signed [ACCW-1:0]        det_ff;
   logic [1:0]                    axis_ff;
   logic                          bitan_ff;
   logic [OUT_BITS-1:0]           res_ff [6];
   logic                          degen_ff;
   logic                          rsp_valid_ff;

   logic signed [COORD_BITS-1:0]  in_pos [3];
   logic signed [COORD_BITS-1:0]  in_tex [2];
   logic                          req_fire;
   tbu_pkg::mul_cmd_type          mul_cmd;
   logic signed [OPW-1:0]         mul_a;
   logic signed [OPW-1:0]         mul_b;
   logic signed [ACCW-1:0]        acc;
   logic                          div_start;
   logic                          div_done;
   logic [OUT_BITS-1:0]           div_result;
   logic [2:0]                    res_idx;
   logic                          last_comp;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         in_pos[c] = req_tdata[c*COORD_BITS +: COORD_BITS];
      end
      for (int c = 0; c < 2; c++) begin
         in_tex[c] = req_tdata[(3+c)*COORD_BITS +: COORD_BITS];
      end
   end

   // A third corner would overwrite the result still waiting at the output.
   assign req_tready = (state_ff == S_IDLE) && !((corner_ff == 2'd2) && rsp_valid_ff);
   assign req_fire   = req_tvalid && req_tready;

   assign res_idx   = 3'(axis_ff) + (bitan_ff ? 3'd3 : 3'd0);
   assign last_comp = bitan_ff && (axis_ff == 2'd2);
   assign div_start = (state_ff == S_DIV_GO);

   // Operand selection for the shared multiplier. Each cross product takes two issues:
   // the first product loads the sum, the second is subtracted from it.
   always_comb begin
      mul_cmd = '0;
      mul_a   = du1_ff;
      mul_b   = dv2_ff;
      unique case (state_ff)
         S_DET_MUL0: begin
            mul_cmd.valid = 1'b1;
            mul_a         = du1_ff;
            mul_b         = dv2_ff;
         end
         S_DET_MUL1: begin
            mul_cmd.valid = 1'b1;
            mul_cmd.sub   = 1'b1;
            mul_a         = du2_ff;
            mul_b         = dv1_ff;
         end
         S_CMP_MUL0: begin
            mul_cmd.valid = 1'b1;
            if (bitan_ff) begin
               mul_a = du1_ff;
               mul_b = e2_ff[axis_ff];
            end else begin
               mul_a = dv2_ff;
               mul_b = e1_ff[axis_ff];
            end
         end
         S_CMP_MUL1: begin
            mul_cmd.valid = 1'b1;
            mul_cmd.sub   = 1'b1;
            if (bitan_ff) begin
               mul_a = du2_ff;
               mul_b = e1_ff[axis_ff];
            end else begin
               mul_a = dv1_ff;
               mul_b = e2_ff[axis_ff];
            end
         end
         default: begin
            mul_cmd = '0;
         end
      endcase
   end

   tbu_mul_acc #(
      .OPW (OPW)
   ) u_mul_acc (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .acc   (acc)
   );

   tbu_divider #(
      .ACC_W (ACCW),
      .OUT_W (OUT_BITS)
   ) u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (acc),
      .den    (det_ff),
      .done   (div_done),
      .result (div_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         corner_ff    <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  if (corner_ff == 2'd2) begin
                     // Edges and texture deltas relative to the first corner.
                     for (int c = 0; c < 3; c++) begin
                        e1_ff[c] <= OPW'(held_pos_ff[1][c]) - OPW'(held_pos_ff[0][c]);
                        e2_ff[c] <= OPW'(in_pos[c]) - OPW'(held_pos_ff[0][c]);
                     end
                     du1_ff    <= OPW'(held_tex_ff[1][0]) - OPW'(held_tex_ff[0][0]);
                     dv1_ff    <= OPW'(held_tex_ff[1][1]) - OPW'(held_tex_ff[0][1]);
                     du2_ff    <= OPW'(in_tex[0]) - OPW'(held_tex_ff[0][0]);
                     dv2_ff    <= OPW'(in_tex[1]) - OPW'(held_tex_ff[0][1]);
                     corner_ff <= 2'd0;
                     state_ff  <= S_DET_MUL0;
                  end else begin
                     for (int c = 0; c < 3; c++) begin
                        held_pos_ff[corner_ff[0]][c] <= in_pos[c];
                     end
                     for (int c = 0; c < 2; c++) begin
                        held_tex_ff[corner_ff[0]][c] <= in_tex[c];
                     end
                     corner_ff <= corner_ff + 2'd1;
                  end
               end
            end
            S_DET_MUL0: begin
               state_ff <= S_DET_MUL1;
            end
            S_DET_MUL1: begin
               state_ff <= S_DET_FILL;
            end
            S_DET_FILL: begin
               state_ff <= S_DET_CHK;
            end
            S_DET_CHK: begin
               if (acc == '0) begin
                  for (int i = 0; i < 6; i++) begin
                     res_ff[i] <= '0;
                  end
                  degen_ff     <= 1'b1;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  det_ff   <= acc;
                  degen_ff <= 1'b0;
                  axis_ff  <= 2'd0;
                  bitan_ff <= 1'b0;
                  state_ff <= S_CMP_MUL0;
               end
            end
            S_CMP_MUL0: begin
               state_ff <= S_CMP_MUL1;
            end
            S_CMP_MUL1: begin
               state_ff <= S_CMP_FILL;
            end
            S_CMP_FILL: begin
               state_ff <= S_DIV_GO;
            end
            S_DIV_GO: begin
               state_ff <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               if (div_done) begin
                  res_ff[res_idx] <= div_result;
                  if (last_comp) begin
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else begin
                     if (axis_ff == 2'd2) begin
                        axis_ff  <= 2'd0;
                        bitan_ff <= 1'b1;
                     end else begin
                        axis_ff <= axis_ff + 2'd1;
                     end
                     state_ff <= S_CMP_MUL0;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      rsp_tdata = '0;
      for (int i = 0; i < 6; i++) begin
         rsp_tdata[i*OUT_BITS +: OUT_BITS] = res_ff[i];
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = degen_ff;

   // A degenerate triangle always reports zero vectors.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == RSP_W'(0)))
      else $error("degenerate result with nonzero vectors");

   // The divider only finishes while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV_WAIT))
      else $error("divider finished outside the wait state");

   // The corner counter never passes the third corner.
   assert property (@(posedge clock) disable iff (reset)
      corner_ff != 2'd3)
      else $error("corner counter out of range");

   // A third corner starts the determinant and clears the corner count.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (corner_ff == 2'd2)) |=> ((state_ff == S_DET_MUL0) && (corner_ff == 2'd0)))
      else $error("third corner did not start the computation");

   // No new computation starts while a result is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DET_MUL0) |-> !rsp_valid_ff)
      else $error("computation started over a pending result");

endmodule

// ===== hdl/tbu_mul_acc.sv =====
// Shared signed multiplier with a registered product and a load/subtract accumulator.
module tbu_mul_acc #(
   parameter int OPW = 17
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tbu_pkg::mul_cmd_type       cmd,
   input  logic signed [OPW-1:0]      op_a,
   input  logic signed [OPW-1:0]      op_b,
   output logic signed [2*OPW:0]      acc
);

   localparam int PRODW = 2 * OPW;
   localparam int ACCW  = 2 * OPW + 1;

   tbu_pkg::mul_cmd_type       cmd_ff;
   logic signed [PRODW-1:0]    prod_ff;
   logic signed [ACCW-1:0]     acc_ff;
   logic signed [ACCW-1:0]     acc_in;
   logic signed [ACCW-1:0]     prod_ext;

   always_comb begin
      prod_ext = ACCW'(prod_ff);
      acc_in   = acc_ff;
      if (cmd_ff.valid) begin
         acc_in = cmd_ff.sub ? (acc_ff - prod_ext) : prod_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff <= '0;
      end else begin
         cmd_ff <= cmd;
      end
      prod_ff <= op_a * op_b;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ===== hdl/tbu_divider.sv =====
// Bit-serial restoring divider giving a rounded, saturated Q16.16 quotient at the default OUT_W.
module tbu_divider #(
   parameter int ACC_W = 35,
   parameter int OUT_W = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [ACC_W-1:0]  num,
   input  logic signed [ACC_W-1:0]  den,
   output logic                     done,
   output logic [OUT_W-1:0]         result
);

   localparam int NUM_W = ACC_W + tbu_pkg::FRAC_SHIFT + 1;
   localparam int EXT_W = NUM_W + OUT_W;
   localparam int CNT_W = $clog2(OUT_W);

   typedef enum logic [2:0] {
      D_IDLE,
      D_PREP,
      D_CHECK,
      D_ITER,
      D_DONE
   } div_state_type;

   div_state_type              state_ff;
   logic signed [ACC_W-1:0]    num_ff;
   logic signed [ACC_W-1:0]    den_ff;
   logic [ACC_W-1:0]           mag_d_ff;
   logic [EXT_W-1:0]           ext_ff;
   logic                       neg_ff;
   logic                       ovf_ff;
   logic [ACC_W-1:0]           rem_ff;
   logic [OUT_W-1:0]           lo_ff;
   logic [OUT_W-1:0]           q_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic                       done_ff;
   logic [OUT_W-1:0]           result_ff;

   logic [ACC_W-1:0]           mag_n;
   logic [ACC_W-1:0]           mag_d;
   logic [NUM_W-1:0]           wide_num;
   logic [NUM_W-1:0]           hi;
   logic                       hi_ge;
   logic [ACC_W:0]             rem_sh;
   logic                       ge;
   logic [ACC_W-1:0]           rem_in;
   logic [OUT_W-1:0]           sat;

   always_comb begin
      mag_n    = num_ff[ACC_W-1] ? ACC_W'(~num_ff + 1'b1) : ACC_W'(num_ff);
      mag_d    = den_ff[ACC_W-1] ? ACC_W'(~den_ff + 1'b1) : ACC_W'(den_ff);
      // Adding half the divisor rounds to nearest, ties away from zero.
      wide_num = (NUM_W'(mag_n) << tbu_pkg::FRAC_SHIFT) + NUM_W'(mag_d >> 1);
      hi       = ext_ff[EXT_W-1:OUT_W];
      hi_ge    = hi >= NUM_W'(mag_d_ff);
      rem_sh   = {rem_ff, lo_ff[OUT_W-1]};
      ge       = rem_sh >= {1'b0, mag_d_ff};
      rem_in   = ge ? ACC_W'(rem_sh - {1'b0, mag_d_ff}) : rem_sh[ACC_W-1:0];
      if (neg_ff) begin
         if (ovf_ff || (q_ff[OUT_W-1] && (|q_ff[OUT_W-2:0]))) begin
            sat = {1'b1, {(OUT_W-1){1'b0}}};
         end else begin
            sat = ~q_ff + 1'b1;
         end
      end else begin
         if (ovf_ff || q_ff[OUT_W-1]) begin
            sat = {1'b0, {(OUT_W-1){1'b1}}};
         end else begin
            sat = q_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            D_IDLE: begin
               if (start) begin
                  num_ff   <= num;
                  den_ff   <= den;
                  ovf_ff   <= 1'b0;
                  state_ff <= D_PREP;
               end
            end
            D_PREP: begin
               mag_d_ff <= mag_d;
               ext_ff   <= EXT_W'(wide_num);
               neg_ff   <= num_ff[ACC_W-1] ^ den_ff[ACC_W-1];
               state_ff <= D_CHECK;
            end
            D_CHECK: begin
               // A quotient of 2^OUT_W or more saturates without iterating.
               if (hi_ge) begin
                  ovf_ff   <= 1'b1;
                  state_ff <= D_DONE;
               end else begin
                  rem_ff   <= hi[ACC_W-1:0];
                  lo_ff    <= ext_ff[OUT_W-1:0];
                  q_ff     <= '0;
                  cnt_ff   <= CNT_W'(OUT_W - 1);
                  state_ff <= D_ITER;
               end
            end
            D_ITER: begin
               rem_ff <= rem_in;
               lo_ff  <= lo_ff << 1;
               q_ff   <= {q_ff[OUT_W-2:0], ge};
               if (cnt_ff == '0) begin
                  state_ff <= D_DONE;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            D_DONE: begin
               result_ff <= sat;
               done_ff   <= 1'b1;
               state_ff  <= D_IDLE;
            end
            default: begin
               state_ff <= D_IDLE;
            end
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule
